/* rtl/mwo_pkg.sv */
// shared types and constants for the multi-wave oscillator core
// used by mwo_shape and multi_wave_oscillator_core; no dependencies
package mwo_pkg;

  // sample range and table word width
  localparam int MAX_BITS = 24;
  localparam int SAMPLE_W = 24;
  localparam logic [4:0] BITS_MIN = 5'd2;
  localparam logic [4:0] BITS_MAX = 5'd24;

  // pi/2 in q2.30 for the sine table series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // wave codes
  localparam logic [2:0] WAVE_SINE  = 3'd0;
  localparam logic [2:0] WAVE_TRI   = 3'd1;
  localparam logic [2:0] WAVE_SAW   = 3'd2;
  localparam logic [2:0] WAVE_PULSE = 3'd3;

  // register indexes
  localparam logic [2:0] REG_WAVE   = 3'd0;
  localparam logic [2:0] REG_DEPTH  = 3'd1;
  localparam logic [2:0] REG_STEP   = 3'd2;
  localparam logic [2:0] REG_PULSE  = 3'd3;
  localparam logic [2:0] REG_COUNT  = 3'd4;

  // per-sample control carried from the phase stage to the shaping stage
  typedef struct packed {
    logic [2:0] wave;
    logic       neg;
    logic       peak;
    logic [4:0] bits;
  } shape_ctl_t;

endpackage

/* rtl/multi_wave_oscillator_core.sv */
// a tick beat's sample passes the shaping stage register and the output register before it leaves on samp_valid
// throughput: one tick per cycle while samp_stall is low; the phase register and the sine rom read set the pace
// back-pressure on samp_stall holds the shaping stage and then stalls ticks
// reset: phase and sample counter cleared, registers to their defaults, pipeline empty
// depends on mwo_pkg and mwo_shape
module multi_wave_oscillator_core #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // tick channel
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  logic                          restart,
  // sample channel
  output logic                          samp_valid,
  input  logic                          samp_stall,
  output logic signed [mwo_pkg::SAMPLE_W-1:0] sample,
  output logic                          last,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import mwo_pkg::*;

  localparam int PW = PHASE_BITS;
  localparam int QS = PW - 2;
  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int MW = PW + 1;
  localparam int XW = PW + 3;

  typedef logic [MAX_BITS-1:0] rom_t [SINE_TABLE_DEPTH];

  // quarter-wave sine, q0.24, taylor series to the x^15 term in q30
  function automatic rom_t build_sine_rom();
    rom_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      v = ((sum << MAX_BITS) + (64'd1 << 29)) >> 30;
      if (v > ((64'd1 << MAX_BITS) - 64'd1)) begin
        v = (64'd1 << MAX_BITS) - 64'd1;
      end
      t[i] = v[MAX_BITS-1:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

  // configuration registers
  logic [2:0]  wave_select;
  logic [4:0]  bit_depth;
  logic [31:0] phase_step;
  logic [16:0] pulse_width;
  logic [31:0] sample_count;

  // oscillator state
  logic [PW-1:0] phase_acc;
  logic [31:0]   samples_done;

  // shaping stage registers
  logic                s1_valid;
  shape_ctl_t          s1_ctl;
  logic [MW-1:0]       s1_mag;
  logic                s1_last;
  logic [MAX_BITS-1:0] rom_q;

  // handshake
  logic tick_accept;
  logic out_take;
  logic s1_adv;

  // phase stage
  logic [PW-1:0]   r;
  logic [31:0]     cnt;
  logic            emit;
  logic            is_last;
  logic [1:0]      quad;
  logic [QS+AW:0]  j_prod;
  logic [AW-1:0]   j;
  logic [AW-1:0]   mirr;
  logic            peak;
  logic [AW-1:0]   rom_addr;
  logic [XW-1:0]   r4;
  logic [XW-1:0]   r2;
  logic [XW-1:0]   xmag;
  logic            neg;
  logic [PW:0]     pulse_limit;
  logic [4:0]      bits;
  shape_ctl_t      ctl_d;
  logic [SAMPLE_W-1:0] shaped;

  localparam logic [XW-1:0] ONE2 = XW'(1) << (PW + 1);
  localparam logic [XW-1:0] ONE4 = XW'(1) << (PW + 2);

  assign cfg_ready   = 1'b1;
  assign out_take    = samp_valid && !samp_stall;
  assign s1_adv      = s1_valid && (!samp_valid || out_take);
  // ticks wait only while the shaping stage is full and cannot move
  assign tick_stall  = s1_valid && !s1_adv;
  assign tick_accept = tick_valid && !tick_stall;

  always_comb begin
    // restart clears the phase and count before this tick's sample
    r   = restart ? '0 : phase_acc;
    cnt = restart ? '0 : samples_done;
    emit    = (wave_select[2] == 1'b0) && (cnt < sample_count);
    is_last = ({1'b0, cnt} + 33'd1) == {1'b0, sample_count};

    // effective bit depth saturates to the supported range
    if (bit_depth < BITS_MIN) begin
      bits = BITS_MIN;
    end else if (bit_depth > BITS_MAX) begin
      bits = BITS_MAX;
    end else begin
      bits = bit_depth;
    end

    // table address: phase within the quadrant scaled to the table depth,
    // mirrored in the odd quadrants where index zero means the exact peak
    quad     = r[PW-1:PW-2];
    j_prod   = (QS+AW+1)'(r[QS-1:0]) * (QS+AW+1)'(SINE_TABLE_DEPTH);
    j        = j_prod[QS +: AW];
    mirr     = AW'((AW+1)'(SINE_TABLE_DEPTH) - {1'b0, j});
    peak     = quad[0] && (j == '0);
    rom_addr = quad[0] ? (peak ? '0 : mirr) : j;

    r4 = {1'b0, r, 2'b00};
    r2 = {2'b00, r, 1'b0};
    pulse_limit = (PW+1)'(pulse_width) << (PW - 16);

    xmag = '0;
    neg  = 1'b0;
    case (wave_select)
      WAVE_SINE: begin
        neg = quad[1];
      end
      WAVE_TRI: begin
        if (quad == 2'b00) begin
          xmag = r4;
        end else if (quad == 2'b11) begin
          xmag = ONE4 - r4;
          neg  = 1'b1;
        end else if (r4 <= ONE2) begin
          xmag = ONE2 - r4;
        end else begin
          xmag = r4 - ONE2;
          neg  = 1'b1;
        end
      end
      WAVE_SAW: begin
        if (!r[PW-1]) begin
          xmag = r2;
        end else begin
          xmag = ONE2 - r2;
          neg  = 1'b1;
        end
      end
      default: begin
        neg = ({1'b0, r} >= pulse_limit);
      end
    endcase

    ctl_d.wave = wave_select;
    ctl_d.neg  = neg;
    ctl_d.peak = peak;
    ctl_d.bits = bits;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select  <= WAVE_SINE;
      bit_depth    <= 5'd16;
      phase_step   <= '0;
      pulse_width  <= 17'd32768;
      sample_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE:  wave_select  <= cfg_data[2:0];
        REG_DEPTH: bit_depth    <= cfg_data[4:0];
        REG_STEP:  phase_step   <= cfg_data;
        REG_PULSE: pulse_width  <= cfg_data[16:0];
        REG_COUNT: sample_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase accumulator and sample counter; updated at the tick beat so the
  // next tick sees the new value without any forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      samples_done <= '0;
    end else if (tick_accept) begin
      if (emit) begin
        phase_acc    <= r + PW'(phase_step);
        samples_done <= cnt + 32'd1;
      end else begin
        phase_acc    <= r;
        samples_done <= cnt;
      end
    end
  end

  // sine rom, registered read at the tick beat, held while the stage waits
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      rom_q <= SINE_ROM[rom_addr];
    end
  end

  // shaping stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_accept) begin
      s1_valid <= emit;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_ctl  <= ctl_d;
      s1_mag  <= MW'(xmag);
      s1_last <= is_last;
    end
  end

  mwo_shape #(
    .PHASE_BITS (PHASE_BITS)
  ) u_shape (
    .ctl        (s1_ctl),
    .mag        (s1_mag),
    .rom_data   (rom_q),
    .sample_val (shaped)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      samp_valid <= 1'b0;
    end else if (s1_adv) begin
      samp_valid <= 1'b1;
    end else if (out_take) begin
      samp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sample <= shaped;
      last   <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // a waiting shaping stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_ctl) && $stable(s1_mag)))
    else $error("shaping stage lost or changed a waiting beat");

  // a tick without restart that makes no sample leaves the phase alone
  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (tick_accept && !restart && !emit) |=> $stable(phase_acc))
    else $error("phase moved on a tick without a sample");

  // restart followed by a sample leaves exactly one sample counted
  a_restart_cnt: assert property (@(posedge clk) disable iff (rst)
    (tick_accept && restart && emit) |=> (samples_done == 32'd1))
    else $error("sample counter wrong after restart");
`endif

endmodule

/* rtl/mwo_shape.sv */
// scaling, clamping and sign of one oscillator sample
// depends on mwo_pkg
module mwo_shape #(
  parameter int PHASE_BITS = 32
) (
  input  mwo_pkg::shape_ctl_t          ctl,
  input  logic [PHASE_BITS:0]          mag,
  input  logic [mwo_pkg::MAX_BITS-1:0] rom_data,
  output logic [mwo_pkg::SAMPLE_W-1:0] sample_val
);
  import mwo_pkg::*;

  localparam int MW  = PHASE_BITS + 1;
  localparam int WW  = MW + MAX_BITS - 1;
  localparam int SHW = $clog2(PHASE_BITS + MAX_BITS + 1);

  logic [4:0]        e;
  logic [MAX_BITS:0] smag;
  logic [WW-1:0]     ext;
  logic [WW-1:0]     amp;
  logic [WW-1:0]     sv;
  logic [WW-1:0]     lim;
  logic [WW-1:0]     m;
  logic [SHW-1:0]    sh;

  always_comb begin
    e    = ctl.bits - 5'd1;
    smag = ctl.peak ? ((MAX_BITS+1)'(1) << MAX_BITS) : {1'b0, rom_data};
    ext  = {mag, {(MAX_BITS-1){1'b0}}};
    sh   = SHW'(PHASE_BITS + MAX_BITS) - SHW'(ctl.bits);
    amp  = WW'(1) << e;
    case (ctl.wave)
      WAVE_SINE: begin
        sv = WW'(smag >> (5'(MAX_BITS) - e));
      end
      WAVE_TRI, WAVE_SAW: begin
        sv = ext >> sh;
      end
      default: begin
        sv = amp;
      end
    endcase
    lim = ctl.neg ? amp : (amp - WW'(1));
    m   = (sv > lim) ? lim : sv;
    sample_val = ctl.neg ? (SAMPLE_W'(0) - m[SAMPLE_W-1:0]) : m[SAMPLE_W-1:0];
  end

endmodule

/* tb/osc_sample_checker.sv */
`timescale 1ns / 100ps
// sample checker for multi_wave_oscillator_core: predicts each tick's sample and compares
// depends on mwo_pkg for wave and register codes
module osc_sample_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tick_valid,
  input  logic                               tick_stall,
  input  logic                               restart,
  input  logic                               samp_valid,
  input  logic                               samp_stall,
  input  logic signed [mwo_pkg::SAMPLE_W-1:0] sample,
  input  logic                               last,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [31:0]                        cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import mwo_pkg::*;

  localparam int SINE_DEPTH = 1024;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } osc_beat_t;

  bit [SAMPLE_W-1:0] sine_rom [SINE_DEPTH];
  osc_beat_t         expected_samples [$];

  // oscillator state and register copies
  bit [31:0] phase_acc;
  bit [31:0] samples_done;
  bit [2:0]  wave_r;
  bit [4:0]  depth_r;
  bit [31:0] step_r;
  bit [16:0] width_r;
  bit [31:0] count_r;
  int        fails;

  // quarter-wave sine rom, same series and rounding as the core
  initial begin
    bit [63:0] x, x2, term, sum, v, div;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 7; k++) begin
        div = 64'((2 * k) * (2 * k + 1));
        term = ((term * x2) >> 30) / div;
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      v = ((sum << MAX_BITS) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << MAX_BITS) - 1) v = (64'd1 << MAX_BITS) - 1;
      sine_rom[i] = v[SAMPLE_W-1:0];
    end
  end

  // clamp a magnitude to [-A, A-1] and wrap to the sample field
  function automatic bit [SAMPLE_W-1:0] fit_depth(bit neg, bit [63:0] mag, int b);
    bit [63:0] amp;
    bit [63:0] v;
    amp = 64'd1 << (b - 1);
    if (!neg) begin
      v = (mag > amp - 1) ? amp - 1 : mag;
    end else begin
      v = (mag > amp) ? amp : mag;
      v = 64'd0 - v;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic bit [SAMPLE_W-1:0] wave_value(bit [2:0] w, bit [31:0] r, int b,
                                                   bit [16:0] width);
    bit [63:0] r64, r4, mag;
    bit [1:0]  quad;
    bit [9:0]  j;
    bit        neg;
    r64 = {32'd0, r};
    quad = r[31:30];
    neg = 1'b0;
    mag = '0;
    case (w)
      WAVE_SINE: begin
        j = r[29:20];
        if (quad[0]) mag = (j == 0) ? (64'd1 << MAX_BITS) : 64'(sine_rom[SINE_DEPTH - j]);
        else mag = 64'(sine_rom[j]);
        neg = quad[1];
        mag = mag >> (MAX_BITS + 1 - b);
      end
      WAVE_TRI: begin
        r4 = r64 << 2;
        if (quad == 2'd0) begin
          mag = r4;
        end else if (quad == 2'd3) begin
          neg = 1'b1;
          mag = (64'd1 << 34) - r4;
        end else if (r4 <= (64'd1 << 33)) begin
          mag = (64'd1 << 33) - r4;
        end else begin
          neg = 1'b1;
          mag = r4 - (64'd1 << 33);
        end
        mag = mag >> (33 - b);
      end
      WAVE_SAW: begin
        if (r64 < (64'd1 << 31)) begin
          mag = (r64 << 1) >> (33 - b);
        end else begin
          neg = 1'b1;
          mag = ((64'd1 << 33) - (r64 << 1)) >> (33 - b);
        end
      end
      default: begin
        neg = r64 >= ({47'd0, width} << 16);
        mag = 64'd1 << (b - 1);
      end
    endcase
    return fit_depth(neg, mag, b);
  endfunction

  function automatic void predict_tick(bit rs);
    int        b;
    osc_beat_t e;
    if (rs) begin
      phase_acc = '0;
      samples_done = '0;
    end
    if (wave_r > WAVE_PULSE || samples_done >= count_r) return;
    b = int'(depth_r);
    if (b < int'(BITS_MIN)) b = int'(BITS_MIN);
    if (b > int'(BITS_MAX)) b = int'(BITS_MAX);
    e.sample = wave_value(wave_r, phase_acc, b, width_r);
    e.last = (samples_done + 32'd1 == count_r);
    expected_samples.push_back(e);
    samples_done = samples_done + 32'd1;
    phase_acc = phase_acc + step_r;
  endfunction

  always @(posedge clk) begin : watch
    osc_beat_t e;
    if (rst) begin
      phase_acc = '0;
      samples_done = '0;
      wave_r = WAVE_SINE;
      depth_r = 5'd16;
      step_r = '0;
      width_r = 17'd32768;
      count_r = '0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVE:  wave_r = cfg_data[2:0];
          REG_DEPTH: depth_r = cfg_data[4:0];
          REG_STEP:  step_r = cfg_data;
          REG_PULSE: width_r = cfg_data[16:0];
          REG_COUNT: count_r = cfg_data;
          default: ;
        endcase
      end
      if (samp_valid && !samp_stall) begin
        if (expected_samples.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected sample beat: sample=%0d last=%0b", sample, last);
        end else begin
          e = expected_samples.pop_front();
          if (sample !== e.sample || last !== e.last) begin
            fails++;
            if (fails <= 10)
              $display("sample mismatch: expected sample=%0d last=%0b, got sample=%0d last=%0b",
                       $signed(e.sample), e.last, sample, last);
          end
        end
      end
      if (tick_valid && !tick_stall) predict_tick(restart);
    end
    fail_count <= fails;
    pending <= expected_samples.size();
  end

  initial begin
    fails = 0;
    fail_count = 0;
    pending = 0;
  end

endmodule

/* tb/multi_wave_oscillator_core_tb.sv */
`timescale 1ns / 100ps
// top of the multi_wave_oscillator_core testbench: clock, reset, tick and register stimulus
// depends on mwo_pkg, multi_wave_oscillator_core and osc_sample_checker
module multi_wave_oscillator_core_tb;
  import mwo_pkg::*;

  // wave codes the core treats as silent
  localparam logic [2:0] WAVE_NONE     = 3'd4;
  localparam logic [2:0] WAVE_SPARE_HI = 3'd7;
  // tick beats to aim for over the whole run
  localparam int TICK_TARGET = 480;
  // cycles without any beat before the run is called hung
  localparam int STUCK_LIMIT = 2000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       tick_valid = 1'b0;
  logic                       tick_stall;
  logic                       restart = 1'b0;
  logic                       samp_valid;
  logic                       samp_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [2:0]                 cfg_index = REG_WAVE;
  logic [31:0]                cfg_data = '0;

  int fail_count;
  int pending;
  int ticks_sent = 0;
  int idle_cycles = 0;
  int stall_hold = 0;
  bit no_idle = 1'b0;

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_wave_oscillator_core dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .restart    (restart),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .sample     (sample),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  osc_sample_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .restart    (restart),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .sample     (sample),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // sample-side back-pressure: alternate stall and free runs of random length
  always @(posedge clk) begin
    if (rst || no_idle) begin
      samp_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (samp_stall) begin
      samp_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      samp_stall <= 1'b1;
      stall_hold <= gap_len();
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (samp_valid && !samp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // write all five registers in index order, valid held high across the beats
  task automatic program_osc(logic [2:0] wave, logic [4:0] depth, logic [31:0] step,
                             logic [16:0] width, logic [31:0] count);
    logic [2:0]  idx  [5];
    logic [31:0] vals [5];
    idx  = '{REG_WAVE, REG_DEPTH, REG_STEP, REG_PULSE, REG_COUNT};
    vals = '{{29'd0, wave}, {27'd0, depth}, step, {15'd0, width}, count};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // tick beats with random gaps and random restarts; restart forced on the first beat if asked
  task automatic send_ticks(int n, int restart_pct, bit first_restart);
    int g;
    for (int k = 0; k < n; k++) begin
      g = gap_len();
      if (g > 0) begin
        tick_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      tick_valid <= 1'b1;
      restart <= (k == 0 && first_restart) || ($urandom_range(0, 99) < restart_pct);
      do @(posedge clk); while (tick_stall);
      ticks_sent++;
    end
    tick_valid <= 1'b0;
  endtask

  // hold the ticks until every predicted sample has come out
  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  // idle point for register writes: drained, plus room for silent ticks in flight
  task automatic quiesce();
    drain();
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [2:0]  wave;
    logic [4:0]  depth;
    logic [31:0] step;
    logic [16:0] width;
    logic [31:0] count;
    int          n;
    int          phase_no;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    // reset defaults: zero count, nothing comes out
    send_ticks(2, 0, 1'b0);
    quiesce();
    // sine at full depth, quarter-turn steps hit both peaks and zero crossings
    program_osc(WAVE_SINE, BITS_MAX, 32'h4000_0000, 17'd32768, 32'd5);
    send_ticks(5, 0, 1'b1);
    quiesce();
    // triangle at the smallest depth, one tick past the count, then a restart
    program_osc(WAVE_TRI, BITS_MIN, 32'h6000_0000, 17'd32768, 32'd4);
    send_ticks(5, 0, 1'b1);
    drain();
    send_ticks(1, 0, 1'b1);
    quiesce();
    // sawtooth, depth above range saturates, step wraps the accumulator
    program_osc(WAVE_SAW, 5'd31, 32'hFFFF_FFFF, 17'd0, 32'd2);
    send_ticks(2, 0, 1'b1);
    quiesce();
    // pulse: zero width always low, depth below range saturates
    program_osc(WAVE_PULSE, 5'd0, 32'h8000_0000, 17'd0, 32'd2);
    send_ticks(2, 0, 1'b1);
    quiesce();
    // pulse: full width always high
    program_osc(WAVE_PULSE, 5'd1, 32'h8000_0000, 17'd65536, 32'd2);
    send_ticks(2, 0, 1'b1);
    quiesce();
    // pulse: width beyond full period
    program_osc(WAVE_PULSE, 5'd12, 32'h4000_0000, 17'h1FFFF, 32'd2);
    send_ticks(2, 0, 1'b1);
    quiesce();
    // silent wave codes
    program_osc(WAVE_NONE, 5'd16, 32'h1234_5678, 17'd100, 32'd10);
    send_ticks(2, 0, 1'b1);
    quiesce();
    program_osc(WAVE_SPARE_HI, 5'd8, 32'h0000_0001, 17'd1, 32'hFFFF_FFFF);
    send_ticks(1, 0, 1'b0);
    quiesce();

    // random part: one register setting per phase
    phase_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      no_idle = (phase_no % 6 == 5);

      if ($urandom_range(0, 99) < 85) wave = 3'($urandom_range(0, 3));
      else wave = 3'($urandom_range(4, 7));

      case ($urandom_range(0, 9))
        0:       depth = 5'($urandom_range(0, 31));
        1:       depth = $urandom_range(0, 1) ? BITS_MIN : BITS_MAX;
        default: depth = 5'($urandom_range(2, 24));
      endcase

      case ($urandom_range(0, 7))
        0:       step = 32'd0;
        1:       step = 32'hFFFF_FFFF;
        2:       step = $urandom_range(1, 65535);
        3:       step = 32'h8000_0000 >> $urandom_range(0, 12);
        default: step = $urandom();
      endcase

      case ($urandom_range(0, 7))
        0:       width = 17'd0;
        1:       width = 17'd65536;
        2:       width = 17'($urandom_range(65537, 131071));
        default: width = 17'($urandom_range(0, 65536));
      endcase

      case ($urandom_range(0, 9))
        0:       count = 32'd0;
        1, 2:    count = $urandom_range(1, 8);
        3, 4:    count = 32'hFFFF_FFFF;
        default: count = $urandom_range(9, 80);
      endcase

      program_osc(wave, depth, step, width, count);
      n = $urandom_range(8, 60);
      send_ticks(n / 2, 6, 1'($urandom_range(0, 1)));
      // now and then let the pipeline run dry mid-phase
      if ($urandom_range(0, 3) == 0 || phase_no == 1) drain();
      else @(posedge clk);
      send_ticks(n - n / 2, 6, 1'b0);
      quiesce();
      phase_no++;
    end

    // settle: nothing outstanding, then a wait for stray beats
    no_idle = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
